>>> hw/rtl/lpmst_pkg.sv
package lpmst_pkg;

  localparam int SLOT_COUNT  = 1024;
  localparam int ENTRY_LIMIT = 512;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int USED_W      = $clog2(ENTRY_LIMIT + 1);
  localparam int PROBE_W     = $clog2(SLOT_COUNT + 1);

  localparam logic [14:0] COUNT_RESET = 15'd16384;
  localparam logic [14:0] COUNT_SAT   = 15'd32767;
  localparam logic [15:0] SUM_SAT     = 16'd65535;
  localparam logic [1:0]  SCORE_MAX   = 2'd2;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [15:0] mv;
    logic [14:0] count;
    logic [15:0] sum;
    logic        colour;
  } slot_entry_t;

endpackage

>>> hw/rtl/linear_probe_move_stats_table.sv
// Each probed slot passes through S_PRD, S_PWAIT and S_PCHK; a record then writes its entry
// in S_UPD, and halving rereads each slot of the key's chain via S_HRD, S_HWAIT and S_HCHK.
// Throughput: one item at a time; busy stays high until the result strobe.
// Each probe step is a registered read of the single-port entry memory plus a key compare.
// Reset: synchronous, active high; sets the limit register to 16384 and the entry count to 0,
// then clears one slot per cycle, all 1024 slots, with busy high. Result shown one cycle on done.
module linear_probe_move_stats_table
  import lpmst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [63:0] position_key,
  input  logic [15:0] move_code,
  input  logic [1:0]  score,
  input  logic        side_to_move,
  output logic        done,
  output logic        found,
  output logic [9:0]  slot_index,
  output logic [14:0] hit_count,
  output logic [15:0] score_sum,
  output logic        table_full,
  output logic        halved
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_PRD, S_PWAIT, S_PCHK, S_UPD, S_HRD, S_HWAIT, S_HCHK, S_DONE
  } state_t;

  state_t state;
  logic [14:0] count_limit;
  logic [USED_W-1:0] entries_used;
  slot_entry_t mem [SLOT_COUNT];
  slot_entry_t rd;
  logic [SLOT_W-1:0] addr, hit_slot;
  logic [PROBE_W-1:0] probes;
  logic op_q, colour_q, cur_valid;
  logic [63:0] key_q;
  logic [15:0] mv_q;
  logic [1:0] score_q;
  logic [14:0] cnt_new, res_cnt;
  logic [15:0] sum_new, res_sum;
  logic we;
  slot_entry_t wd;
  logic [SLOT_W-1:0] waddr;

  assign cfg_ready = !busy;
  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wd;
    rd <= mem[addr];
  end

  // combinational update of the hit entry
  always_comb begin
    logic [14:0] c0;
    logic [15:0] s0;
    logic [16:0] s1;
    c0 = cur_valid ? rd.count : '0;
    s0 = cur_valid ? rd.sum : '0;
    cnt_new = (c0 == COUNT_SAT) ? COUNT_SAT : c0 + 15'd1;
    s1 = {1'b0, s0} + {15'd0, score_q};
    sum_new = s1[16] ? SUM_SAT : s1[15:0];
  end

  always_comb begin
    we = 1'b0;
    waddr = addr;
    wd = rd;
    if (state == S_CLR) begin
      we = 1'b1;
      wd = '0;
    end else if (state == S_UPD && !(op_q == OP_LOOKUP)) begin
      we = 1'b1;
      wd.count = cnt_new;
      wd.sum = sum_new;
      if (!cur_valid) begin
        wd.valid = 1'b1;
        wd.key = key_q;
        wd.mv = mv_q;
        wd.colour = colour_q;
      end
    end else if (state == S_HCHK && rd.valid && rd.key == key_q) begin
      we = 1'b1;
      wd.count = 15'((16'(rd.count) + 16'd1) >> 1);
      wd.sum = 16'((17'(rd.sum) + 17'd1) >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      addr <= '0;
      count_limit <= COUNT_RESET;
      entries_used <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) count_limit <= cfg_data;
      unique case (state)
        S_CLR: begin
          if (addr == SLOT_W'(SLOT_COUNT - 1)) begin
            addr <= '0;
            state <= S_IDLE;
          end else addr <= addr + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            op_q <= opcode;
            key_q <= position_key;
            mv_q <= move_code;
            score_q <= (score > SCORE_MAX) ? SCORE_MAX : score;
            colour_q <= side_to_move;
            addr <= position_key[SLOT_W-1:0];
            probes <= '0;
            found <= 1'b0; slot_index <= '0; hit_count <= '0; score_sum <= '0;
            table_full <= 1'b0; halved <= 1'b0;
            state <= S_PRD;
          end
        end
        S_PRD: state <= S_PWAIT;
        S_PWAIT: state <= S_PCHK;
        S_PCHK: begin
          cur_valid <= rd.valid;
          if (!rd.valid) begin
            if (op_q == OP_LOOKUP) state <= S_DONE;
            else if (entries_used >= USED_W'(ENTRY_LIMIT)) begin
              table_full <= 1'b1; state <= S_DONE;
            end else state <= S_UPD;
          end else if (rd.key == key_q && rd.mv == mv_q) begin
            if (op_q == OP_LOOKUP) begin
              found <= 1'b1; slot_index <= 10'(addr);
              hit_count <= rd.count; score_sum <= rd.sum;
              state <= S_DONE;
            end else state <= S_UPD;
          end else if (probes == PROBE_W'(SLOT_COUNT - 1)) begin
            table_full <= !(op_q == OP_LOOKUP);
            state <= S_DONE;
          end else begin
            probes <= probes + 1'b1;
            addr <= (addr == SLOT_W'(SLOT_COUNT - 1)) ? '0 : addr + 1'b1;
            state <= S_PRD;
          end
        end
        S_UPD: begin
          if (!cur_valid) entries_used <= entries_used + 1'b1;
          hit_slot <= addr;
          found <= 1'b1; slot_index <= 10'(addr);
          res_cnt <= cnt_new; res_sum <= sum_new;
          hit_count <= cnt_new; score_sum <= sum_new;
          if (cnt_new >= count_limit) begin
            halved <= 1'b1;
            addr <= key_q[SLOT_W-1:0];
            probes <= '0;
            state <= S_HRD;
          end else state <= S_DONE;
        end
        S_HRD: state <= S_HWAIT;
        S_HWAIT: state <= S_HCHK;
        S_HCHK: begin
          if (rd.valid && rd.key == key_q && addr == hit_slot) begin
            hit_count <= 15'((16'(res_cnt) + 16'd1) >> 1);
            score_sum <= 16'((17'(res_sum) + 17'd1) >> 1);
          end
          if (!rd.valid || probes == PROBE_W'(SLOT_COUNT - 1)) state <= S_DONE;
          else begin
            probes <= probes + 1'b1;
            addr <= (addr == SLOT_W'(SLOT_COUNT - 1)) ? '0 : addr + 1'b1;
            state <= S_HRD;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_full_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(found && table_full)) else $error("found with table_full");
  a_halved_rec: assert property (@(posedge clk) disable iff (rst)
    (done && halved) |-> found) else $error("halved without entry");
  a_used_cap: assert property (@(posedge clk) disable iff (rst)
    entries_used <= USED_W'(ENTRY_LIMIT)) else $error("entries over limit");
  a_start_ack: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("item not taken");

endmodule
